// ===== sv/tpef_pkg.sv =====
// Package: request and result payload types and filter constants.
`timescale 1ns / 1ps
package tpef_pkg;

  typedef struct packed {
    logic               command;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               pen_up;
  } tpef_req_t;

  typedef struct packed {
    logic               event_valid;
    logic [1:0]         event_kind;
    logic signed [15:0] event_x;
    logic signed [15:0] event_y;
    logic               sample_queued;
    logic               sample_dropped;
  } tpef_res_t;

  localparam logic [1:0] KindDown = 2'd0;
  localparam logic [1:0] KindMove = 2'd1;
  localparam logic [1:0] KindUp   = 2'd2;
  localparam logic [1:0] KindNone = 2'd3;

  localparam logic [2:0] RegPanelX  = 3'd0;
  localparam logic [2:0] RegPanelY  = 3'd1;
  localparam logic [2:0] RegScreenX = 3'd2;
  localparam logic [2:0] RegScreenY = 3'd3;
  localparam logic [2:0] RegOriginX = 3'd4;
  localparam logic [2:0] RegOriginY = 3'd5;
  localparam logic [2:0] RegFlip    = 3'd6;
  localparam logic [2:0] RegMode    = 3'd7;

  localparam logic [1:0] ModeRaw    = 2'd0;
  localparam logic [1:0] ModeMapped = 2'd1;
  localparam logic [1:0] ModeNone   = 2'd3;

  localparam int StepLimit   = 120;
  localparam int ChangeLimit = 60;
  localparam int MoveLimit   = 4;
  localparam int HoldLimit   = 12;
  localparam int MoveRoom    = 10;

endpackage

// ===== sv/touch_pen_event_filter_top.sv =====
// Touch-pen event filter: outlier filter, move tracker, serial mapper, event queue.
//
//  channel | signals                           | direction
//  request | req_valid_i, req_ready_o, req_i   | in
//  result  | res_valid_o, res_ready_i, res_o   | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i   | in
//
// A read request, a filtered-out sample or a sample with no event goes from
// acceptance straight to the output state; a raw event passes the push state
// first. A mapped event uses one shared 34-bit restoring divider, per axis a
// multiply then 34 divide steps, x then y. Reset is asynchronous; the store
// needs no clearing. A stalled result holds in the output register; requests wait.
`timescale 1ns / 1ps
module touch_pen_event_filter_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  tpef_pkg::tpef_req_t req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output tpef_pkg::tpef_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import tpef_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int DW = 34;  // dividend magnitude width (17b diff * 16b span)

  typedef enum logic [2:0] {
    StIdle, StMul, StDiv, StPush, StOut
  } state_e;

  // configuration registers
  logic [15:0] pspan_x_q, pspan_y_q, sspan_x_q, sspan_y_q;
  logic signed [15:0] org_x_q, org_y_q;
  logic [1:0] flip_q, mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pspan_x_q <= '1; pspan_y_q <= '1; sspan_x_q <= '1; sspan_y_q <= '1;
      org_x_q <= '0; org_y_q <= '0; flip_q <= '0; mode_q <= ModeMapped;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPanelX:  pspan_x_q <= cfg_data_i;
        RegPanelY:  pspan_y_q <= cfg_data_i;
        RegScreenX: sspan_x_q <= cfg_data_i;
        RegScreenY: sspan_y_q <= cfg_data_i;
        RegOriginX: org_x_q <= cfg_data_i;
        RegOriginY: org_y_q <= cfg_data_i;
        RegFlip:    flip_q <= cfg_data_i[1:0];
        RegMode:    mode_q <= cfg_data_i[1:0];
        default:    ;
      endcase
    end
  end

  state_e state_q;
  logic [1:0] acc_cnt_q;
  logic signed [15:0] prev_x_q, prev_y_q, last_x_q, last_y_q;
  logic [7:0] pstep_x_q, pstep_y_q;  // last step, low 8 bits (over 120 after a rejected warm-up)
  logic touching_q, lifted_q;
  logic [3:0] hold_q;
  logic [PW-1:0] rd_ptr_q, wr_ptr_q;
  logic [1:0] kind_q;
  logic axis_q;                       // 0 x, 1 y
  logic [5:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [16:0] rem_q;
  logic neg_q;
  logic signed [16:0] diff_q;
  logic [15:0] mx_q, my_q;
  logic signed [15:0] ev_x_q, ev_y_q;
  logic [33:0] mem_q [QUEUE_DEPTH];

  // filter combinational view of the incoming sample
  logic signed [16:0] dx_s, dy_s;
  logic [16:0] adx, ady;
  logic signed [9:0] chx, chy;
  logic [9:0] achx, achy;
  logic ok_ph2, ok_ph1;

  always_comb begin
    dx_s = 17'(req_i.sample_x) - 17'(prev_x_q);
    dy_s = 17'(req_i.sample_y) - 17'(prev_y_q);
    adx  = dx_s[16] ? 17'(-dx_s) : 17'(dx_s);
    ady  = dy_s[16] ? 17'(-dy_s) : 17'(dy_s);
    chx  = 10'(adx[7:0]) - 10'(pstep_x_q);
    chy  = 10'(ady[7:0]) - 10'(pstep_y_q);
    achx = chx[9] ? 10'(-chx) : 10'(chx);
    achy = chy[9] ? 10'(-chy) : 10'(chy);
    ok_ph1 = (adx <= 17'(StepLimit)) && (ady <= 17'(StepLimit));
    ok_ph2 = ok_ph1 && (achx <= 10'(ChangeLimit)) && (achy <= 10'(ChangeLimit));
  end

  // move gating and tracker on the sample
  logic signed [16:0] mvx, mvy;
  logic [16:0] amx, amy;
  logic [3:0] hold_inc;
  logic big_move;
  always_comb begin
    mvx = 17'(req_i.sample_x) - 17'(last_x_q);
    mvy = 17'(req_i.sample_y) - 17'(last_y_q);
    amx = mvx[16] ? 17'(-mvx) : 17'(mvx);
    amy = mvy[16] ? 17'(-mvy) : 17'(mvy);
    big_move = (amx > 17'(MoveLimit)) || (amy > 17'(MoveLimit));
    hold_inc = hold_q + 4'd1;
  end

  // queue occupancy; free slots count as the full depth when empty
  logic [PW-1:0] wr_next;
  logic [PW:0] gap;
  logic q_full, room_low, push_drop;
  always_comb begin
    wr_next  = (32'(wr_ptr_q) + 32'd1 >= 32'(QUEUE_DEPTH)) ? '0 : PW'(wr_ptr_q + 1'b1);
    gap      = (rd_ptr_q > wr_ptr_q) ? (PW+1)'(32'(rd_ptr_q) - 32'(wr_ptr_q))
               : (PW+1)'(32'(QUEUE_DEPTH) + 32'(rd_ptr_q) - 32'(wr_ptr_q));
    room_low = (32'(gap) < MoveRoom);
    q_full   = (wr_next == rd_ptr_q);
    push_drop = (kind_q == KindMove) ? (room_low || q_full) : q_full;
  end

  // shared multiply / restoring divide step
  logic [16:0] trial;
  logic [15:0] div_s;
  logic [15:0] mul_s;
  logic signed [16:0] org_s;
  logic signed [15:0] pos_s;
  logic flip_s;
  always_comb begin
    div_s  = axis_q ? pspan_y_q : pspan_x_q;
    mul_s  = axis_q ? sspan_y_q : sspan_x_q;
    org_s  = axis_q ? 17'(org_y_q) : 17'(org_x_q);
    pos_s  = axis_q ? ev_y_q : ev_x_q;
    flip_s = axis_q ? flip_q[1] : flip_q[0];
    trial  = {rem_q[15:0], quo_q[DW-1]};
  end

  logic [15:0] quo_lo;
  assign quo_lo = neg_q ? 16'(-quo_q) : quo_q[15:0];

  logic [DW-1:0] prod;
  logic [16:0] mag;
  assign mag  = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
  assign prod = DW'(mag) * DW'(mul_s);

  // event store write
  always_ff @(posedge clk_i) begin
    if (state_q == StPush && !push_drop)
      mem_q[wr_ptr_q] <= {kind_q, ev_x_q, ev_y_q};
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; acc_cnt_q <= '0; prev_x_q <= '0; prev_y_q <= '0;
      pstep_x_q <= '0; pstep_y_q <= '0; touching_q <= 1'b0; lifted_q <= 1'b0;
      last_x_q <= '0; last_y_q <= '0; hold_q <= '0; rd_ptr_q <= '0;
      wr_ptr_q <= '0; kind_q <= KindNone; axis_q <= 1'b0; cnt_q <= '0;
      quo_q <= '0; rem_q <= '0; neg_q <= 1'b0; diff_q <= '0; mx_q <= '0;
      my_q <= '0; ev_x_q <= '0; ev_y_q <= '0; res_valid_o <= 1'b0;
      res_o <= '0;
    end else begin
      case (state_q)
        StIdle: if (req_valid_i) begin
          if (req_i.command) begin
            // read request
            if (rd_ptr_q != wr_ptr_q) begin
              res_o <= {1'b1, mem_q[rd_ptr_q], 2'b00};
              rd_ptr_q <= (32'(rd_ptr_q) + 32'd1 >= 32'(QUEUE_DEPTH)) ? '0
                          : PW'(rd_ptr_q + 1'b1);
            end else begin
              res_o <= '0;
            end
            state_q <= StOut;
          end else begin
            logic pass;
            logic [1:0] kind;
            pass = 1'b1;
            res_o <= '0;
            if (req_i.pen_up) begin
              lifted_q <= 1'b1; acc_cnt_q <= '0;
            end else begin
              lifted_q <= 1'b0;
              prev_x_q <= req_i.sample_x; prev_y_q <= req_i.sample_y;
              pass = 1'b0;
              if (acc_cnt_q == 2'd0) acc_cnt_q <= 2'd1;
              else if (acc_cnt_q == 2'd1) begin
                pstep_x_q <= adx[7:0];
                if (adx <= 17'(StepLimit)) pstep_y_q <= ady[7:0];
                acc_cnt_q <= (adx <= 17'(StepLimit) && ady <= 17'(StepLimit))
                             ? 2'd2 : 2'd0;
              end else if (!ok_ph2) begin
                acc_cnt_q <= '0;
                if (adx <= 17'(StepLimit) && achx <= 10'(ChangeLimit))
                  pstep_x_q <= adx[7:0];
              end else begin
                pstep_x_q <= adx[7:0]; pstep_y_q <= ady[7:0];
                pass = 1'b1;
              end
              // small moves are held until the hold count runs out
              if (!pass) hold_q <= '0;
              else if (touching_q && !big_move && hold_inc <= 4'(HoldLimit)) begin
                hold_q <= hold_inc;
                pass = 1'b0;
              end
            end
            kind = KindNone;
            if (pass) begin
              hold_q <= '0;
              if (touching_q) begin
                if (!req_i.pen_up) kind = KindMove;
                else begin kind = KindUp; touching_q <= 1'b0; end
              end else if (!req_i.pen_up) begin
                kind = KindDown; touching_q <= 1'b1;
              end
            end
            kind_q <= kind;
            if (kind == KindUp) begin
              ev_x_q <= last_x_q; ev_y_q <= last_y_q;
            end else begin
              ev_x_q <= req_i.sample_x; ev_y_q <= req_i.sample_y;
              if (kind != KindNone) begin
                last_x_q <= req_i.sample_x; last_y_q <= req_i.sample_y;
              end
            end
            if (kind == KindNone || mode_q == ModeNone) state_q <= StOut;
            else if (mode_q == ModeRaw) state_q <= StPush;
            else begin
              axis_q <= 1'b0; cnt_q <= '0; state_q <= StMul;
            end
          end
        end
        StMul: begin
          // the first step forms the difference, the second the product
          if (cnt_q == 6'd0) begin
            diff_q <= flip_s ? 17'(org_s - 17'(pos_s)) : 17'(17'(pos_s) - org_s);
            cnt_q <= 6'd1;
          end else begin
            quo_q <= prod; rem_q <= '0; neg_q <= diff_q[16];
            cnt_q <= 6'(DW); state_q <= StDiv;
          end
        end
        StDiv: begin
          if (cnt_q != 6'd0) begin
            if (trial >= {1'b0, div_s}) begin
              rem_q <= trial - {1'b0, div_s};
              quo_q <= {quo_q[DW-2:0], 1'b1};
            end else begin
              rem_q <= trial;
              quo_q <= {quo_q[DW-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 6'd1;
          end else begin
            if (!axis_q) begin
              mx_q <= (div_s == '0) ? '0 : quo_lo;
              axis_q <= 1'b1; cnt_q <= '0; state_q <= StMul;
            end else begin
              my_q <= (div_s == '0) ? '0 : quo_lo;
              ev_x_q <= mx_q; ev_y_q <= (div_s == '0) ? '0 : quo_lo;
              state_q <= StPush;
            end
          end
        end
        StPush: begin
          // queued or dropped flag only
          res_o <= {35'd0, !push_drop, push_drop};
          if (!push_drop) wr_ptr_q <= wr_next;
          state_q <= StOut;
        end
        StOut: begin
          if (!res_valid_o) res_valid_o <= 1'b1;
          else if (res_ready_i) begin
            res_valid_o <= 1'b0; state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign req_ready_o = (state_q == StIdle);

endmodule

// ===== tb/touch_pen_event_filter_top_tb.sv =====
// Testbench for the touch-pen event filter: random strokes checked against an in-bench predictor.
`timescale 1ns / 1ps
module touch_pen_event_filter_top_tb;
  import tpef_pkg::*;

  localparam int          Depth       = 32;
  localparam logic        CmdSample   = 1'b0;
  localparam logic        CmdRead     = 1'b1;
  localparam logic [1:0]  ModeCompare = 2'd2;
  localparam int          CycleLimit  = 3000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
  } stored_event_t;

  // Scoreboard: tracks filter, tracker and queue state and holds pending results
  class event_scoreboard;
    int unsigned   span_px, span_py, span_sx, span_sy;
    int            org_x, org_y;
    logic [1:0]    flips, mode;
    int            phase_cnt, last_raw_x, last_raw_y, last_step_x, last_step_y;
    bit            pen_touching, pen_lifted;
    int            move_x, move_y;
    int            held;
    stored_event_t ring[Depth];
    int            rd_ptr, wr_ptr;
    tpef_res_t     pending_q[$];
    int            errors;

    function new();
      span_px = 32'hffff; span_py = 32'hffff; span_sx = 32'hffff; span_sy = 32'hffff;
      org_x = 0; org_y = 0; flips = 2'd0; mode = ModeMapped;
      phase_cnt = 0; last_raw_x = 0; last_raw_y = 0; last_step_x = 0; last_step_y = 0;
      pen_touching = 0; pen_lifted = 0; move_x = 0; move_y = 0; held = 0;
      rd_ptr = 0; wr_ptr = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        RegPanelX:  span_px = 32'(val);
        RegPanelY:  span_py = 32'(val);
        RegScreenX: span_sx = 32'(val);
        RegScreenY: span_sy = 32'(val);
        RegOriginX: org_x = 32'($signed(val));
        RegOriginY: org_y = 32'($signed(val));
        RegFlip:    flips = val[1:0];
        default:    mode = val[1:0];
      endcase
    endfunction

    function int abs_diff(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Outlier rejection: two warm-up samples, then step and step-change limits
    function bit accept_sample(int x, int y);
      int dx, dy;
      if (phase_cnt == 0) begin
        phase_cnt = 1;
        return 0;
      end
      if (phase_cnt == 1) begin
        phase_cnt = 2;
        last_step_x = abs_diff(x, last_raw_x);
        if (last_step_x > StepLimit) begin phase_cnt = 0; return 0; end
        last_step_y = abs_diff(y, last_raw_y);
        if (last_step_y > StepLimit) phase_cnt = 0;
        return 0;
      end
      dx = abs_diff(x, last_raw_x);
      if (dx > StepLimit || abs_diff(dx, last_step_x) > ChangeLimit) begin
        phase_cnt = 0;
        return 0;
      end
      last_step_x = dx;
      dy = abs_diff(y, last_raw_y);
      if (dy > StepLimit || abs_diff(dy, last_step_y) > ChangeLimit) begin
        phase_cnt = 0;
        return 0;
      end
      last_step_y = dy;
      return 1;
    endfunction

    function bit move_allowed(int x, int y);
      if (!pen_touching) return 1;
      if (abs_diff(x, move_x) > MoveLimit || abs_diff(y, move_y) > MoveLimit) return 1;
      held = (held + 1) & 15;
      return held > HoldLimit;
    endfunction

    function logic [15:0] scale(int v, int org, bit flip, int unsigned mul, int unsigned dvs);
      longint d, q;
      d = flip ? longint'(org) - v : longint'(v) - org;
      if (dvs == 0) return 16'd0;
      q = (d * longint'(mul)) / longint'(dvs);
      return q[15:0];
    endfunction

    function tpef_res_t predict(tpef_req_t r);
      tpef_res_t   res;
      int          x, y, room;
      logic [1:0]  kind;
      logic [15:0] ox, oy;
      res = '0;
      x = int'(r.sample_x);
      y = int'(r.sample_y);
      if (r.command == CmdRead) begin
        if (rd_ptr != wr_ptr) begin
          res.event_valid = 1'b1;
          res.event_kind  = ring[rd_ptr].kind;
          res.event_x     = ring[rd_ptr].x;
          res.event_y     = ring[rd_ptr].y;
          rd_ptr = (rd_ptr + 1) % Depth;
        end
        return res;
      end
      if (r.pen_up) begin
        pen_lifted = 1;
        phase_cnt = 0;
      end else begin
        pen_lifted = 0;
        if (!accept_sample(x, y)) begin
          last_raw_x = x; last_raw_y = y; held = 0;
          return res;
        end
        last_raw_x = x; last_raw_y = y;
        if (!move_allowed(x, y)) return res;
      end
      held = 0;
      // down / move / up tracking
      if (pen_touching) begin
        if (pen_lifted) begin
          pen_touching = 0;
          kind = KindUp;
        end else begin
          kind = KindMove;
        end
      end else if (pen_lifted) begin
        return res;
      end else begin
        pen_touching = 1;
        kind = KindDown;
      end
      if (kind == KindUp) begin
        x = move_x; y = move_y;
      end else begin
        move_x = x; move_y = y;
      end
      if (mode == ModeNone) return res;
      if (mode == ModeRaw) begin
        ox = x[15:0]; oy = y[15:0];
      end else begin
        ox = scale(x, org_x, flips[0], span_sx, span_px);
        oy = scale(y, org_y, flips[1], span_sy, span_py);
      end
      room = (rd_ptr > wr_ptr) ? rd_ptr - wr_ptr : Depth + rd_ptr - wr_ptr;
      if (kind == KindMove && room < MoveRoom) begin
        res.sample_dropped = 1'b1;
      end else if ((wr_ptr + 1) % Depth == rd_ptr) begin
        res.sample_dropped = 1'b1;
      end else begin
        ring[wr_ptr] = '{kind: kind, x: ox, y: oy};
        wr_ptr = (wr_ptr + 1) % Depth;
        res.sample_queued = 1'b1;
      end
      return res;
    endfunction

    function void note_request(tpef_req_t r);
      pending_q.push_back(predict(r));
    endfunction

    function void check_result(tpef_res_t got);
      tpef_res_t exp_res;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (got.event_valid !== exp_res.event_valid) begin
        $display("%0t: event_valid exp %0d got %0d", $time, exp_res.event_valid, got.event_valid);
        errors++;
      end
      if (got.event_kind !== exp_res.event_kind) begin
        $display("%0t: event_kind exp %0d got %0d", $time, exp_res.event_kind, got.event_kind);
        errors++;
      end
      if (got.event_x !== exp_res.event_x) begin
        $display("%0t: event_x exp %0d got %0d", $time, exp_res.event_x, got.event_x);
        errors++;
      end
      if (got.event_y !== exp_res.event_y) begin
        $display("%0t: event_y exp %0d got %0d", $time, exp_res.event_y, got.event_y);
        errors++;
      end
      if (got.sample_queued !== exp_res.sample_queued) begin
        $display("%0t: sample_queued exp %0d got %0d", $time, exp_res.sample_queued,
                 got.sample_queued);
        errors++;
      end
      if (got.sample_dropped !== exp_res.sample_dropped) begin
        $display("%0t: sample_dropped exp %0d got %0d", $time, exp_res.sample_dropped,
                 got.sample_dropped);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        req_valid_i, req_ready_o, res_valid_o, res_ready_i;
  tpef_req_t   req_i;
  tpef_res_t   res_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  event_scoreboard sb = new();
  int tx_idle_pct = 32;
  int rx_idle_pct = 69;
  int rx_hold_left = 0;
  int cycles = 0;

  touch_pen_event_filter_top #(.QUEUE_DEPTH(Depth)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("touch_pen_event_filter_top_tb NOT OK");
      $finish;
    end
  end

  // Result side: check accepted results, then pick next ready
  initial begin
    res_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_valid_o && res_ready_i) sb.check_result(res_o);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send(input tpef_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_i       <= r;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
  endtask

  task automatic send_sample(input int x, input int y, input bit up);
    tpef_req_t r;
    r.command  = CmdSample;
    r.sample_x = x[15:0];
    r.sample_y = y[15:0];
    r.pen_up   = up;
    send(r);
  endtask

  task automatic send_read();
    tpef_req_t r;
    r = {CmdRead, 32'($urandom), 1'($urandom)};
    send(r);
  endtask

  // Pause the requests until every result is in, plus the divider latency
  task automatic drain();
    req_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // Random strokes: smooth drags, still presses, outliers and noise, reads mixed in
  task automatic run_strokes(input int n, input int read_pct);
    int sent, x, y, vx, vy, len, style;
    sent = 0;
    while (sent < n) begin
      style = $urandom_range(9);
      x = $urandom_range(1) ? $signed(16'($urandom)) : ($urandom_range(1) ? 32760 : -32760);
      y = $signed(16'($urandom));
      vx = $urandom_range(60) - 30;
      vy = $urandom_range(60) - 30;
      if (style < 2) begin
        vx = 0; vy = 0;
      end
      len = $urandom_range(40, 3);
      for (int i = 0; i < len; i++) begin
        if (style == 9) begin
          x = $signed(16'($urandom)); y = $signed(16'($urandom));
        end else if (style < 2) begin
          x = clamp16(x + $urandom_range(4) - 2);
          y = clamp16(y + $urandom_range(4) - 2);
        end else begin
          vx += $urandom_range(10) - 5; vy += $urandom_range(10) - 5;
          if (vx > 60 || vx < -60) vx = 0;
          if (vy > 60 || vy < -60) vy = 0;
          x = clamp16(x + vx); y = clamp16(y + vy);
          if ($urandom_range(29) == 0) x = clamp16(x + 200);
        end
        send_sample(x, y, 1'b0);
        sent++;
        if ($urandom_range(99) < read_pct) begin send_read(); sent++; end
      end
      for (int i = $urandom_range(3, 1); i > 0; i--) begin
        send_sample($signed(16'($urandom)), $signed(16'($urandom)), 1'b1);
        sent++;
        if ($urandom_range(99) < read_pct) begin send_read(); sent++; end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegPanelX;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, lift without touch, edges, step limits, hold expiry
    send_read();
    send_sample(0, 0, 1'b1);
    send_sample(32767, -32768, 1'b0);
    send_sample(32767, -32768, 1'b0);
    send_sample(32767, -32768, 1'b0);
    send_sample(32700, -32700, 1'b0);
    send_sample(100, 100, 1'b0);
    send_sample(110, 100, 1'b0);
    send_sample(120, 100, 1'b0);
    send_sample(130, 100, 1'b0);
    send_sample(131, 101, 1'b0);
    for (int i = 0; i < 13; i++) send_sample(131, 101, 1'b0);
    send_sample(250, 100, 1'b0);
    send_sample(-32768, 32767, 1'b1);
    send_read();
    send_read();
    drain();

    // Raw coordinates, sender 32 / receiver 69 idle, long receiver hold-off
    write_reg(RegMode, 16'(ModeRaw));
    fork
      run_strokes(200, 30);
      begin
        repeat (200) @(posedge clk_i);
        rx_hold_left = 3000;
      end
    join
    run_strokes(150, 10);
    drain();

    // Flipped mapping via unused mode code 2 with edge origins; idle swapped
    tx_idle_pct = 69; rx_idle_pct = 32;
    write_reg(RegMode, 16'(ModeCompare));
    write_reg(RegFlip, 16'd3);
    write_reg(RegOriginX, 16'h8000);
    write_reg(RegOriginY, 16'h7fff);
    write_reg(RegPanelX, 16'd1);
    write_reg(RegPanelY, 16'd3);
    write_reg(RegScreenX, 16'($urandom));
    write_reg(RegScreenY, 16'hffff);
    run_strokes(300, 35);
    drain();

    // Zero spans, rare reads so the queue fills
    write_reg(RegMode, 16'(ModeMapped));
    write_reg(RegFlip, 16'd1);
    write_reg(RegPanelX, 16'd0);
    write_reg(RegPanelY, 16'hffff);
    write_reg(RegScreenX, 16'hffff);
    write_reg(RegScreenY, 16'd0);
    run_strokes(200, 3);
    drain();

    // No-events mode, no idling from here on
    tx_idle_pct = 0; rx_idle_pct = 0;
    write_reg(RegMode, 16'(ModeNone));
    run_strokes(100, 40);
    drain();

    write_reg(RegMode, 16'(ModeMapped));
    write_reg(RegFlip, 16'd2);
    write_reg(RegPanelX, 16'($urandom_range(65535, 1)));
    write_reg(RegPanelY, 16'($urandom_range(65535, 1)));
    write_reg(RegScreenX, 16'($urandom));
    write_reg(RegScreenY, 16'($urandom));
    write_reg(RegOriginX, 16'($urandom));
    write_reg(RegOriginY, 16'($urandom));
    for (int i = 0; i < 40; i++) send_read();
    run_strokes(300, 30);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("touch_pen_event_filter_top_tb OK");
    end else begin
      $display("touch_pen_event_filter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
